>>> rtl/round_robin_thread_scheduler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin thread scheduler
// Immediate-implication and next-cycle forms, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define RRTS_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");

// next-cycle implication
`define RRTS_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");

`endif

>>> rtl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types, codes and sizes shared by the thread scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int SLOTS  = 256;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int GRP    = 16;
    localparam int NGRP   = SLOTS / GRP;
    localparam int GRP_W  = $clog2(NGRP);
    localparam int BIT_W  = $clog2(GRP);
    localparam int CNT_W  = SLOT_W + 1;

    localparam logic [2:0] ACT_YIELD  = 3'd0;
    localparam logic [2:0] ACT_CREATE = 3'd1;
    localparam logic [2:0] ACT_SLEEP  = 3'd2;
    localparam logic [2:0] ACT_WAKEUP = 3'd3;
    localparam logic [2:0] ACT_JOIN   = 3'd4;
    localparam logic [2:0] ACT_EXIT   = 3'd5;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NOSLOT  = 2'd1;
    localparam logic [1:0] STS_BADJOIN = 2'd2;
    localparam logic [1:0] STS_OVF     = 2'd3;

    localparam logic [1:0] SS_UNUSED = 2'd0;
    localparam logic [1:0] SS_RUN    = 2'd1;
    localparam logic [1:0] SS_SLEEP  = 2'd2;
    localparam logic [1:0] SS_DEAD   = 2'd3;

    typedef struct packed {
        logic [1:0]        state;
        logic              jv;
        logic [SLOT_W-1:0] js;
        logic [31:0]       ident;
    } t_ent;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        t_ent              wr_ent;
    } t_tbl_req;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [SLOT_W-1:0] data;
    } t_q_req;

    typedef struct packed {
        logic              set_free;
        logic              clr_free;
        logic [SLOT_W-1:0] addr;
    } t_free_req;

endpackage

>>> rtl/rrts_slot_tbl.sv
// ----------------------------------------------------------------------------
// rrts_slot_tbl
// Slot table memory: state, joiner and id per slot, registered read.
// ----------------------------------------------------------------------------
module rrts_slot_tbl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rrts_pkg::t_tbl_req i_req,
    output rrts_pkg::t_ent    o_rd_ent
);
    import rrts_pkg::*;

    t_ent r_mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    t_ent r_rd;
    t_ent dflt;

    // an entry never written reads as zero, but slot 0 reads as running
    always_comb begin
        dflt = '0;
        if (i_req.rd_addr == '0) begin
            dflt.state = SS_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_ent;
        end
        if (i_req.rd_en) begin
            r_rd <= r_vld[i_req.rd_addr] ? r_mem[i_req.rd_addr] : dflt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_ent = r_rd;
endmodule

>>> rtl/rrts_ready_q.sv
// ----------------------------------------------------------------------------
// rrts_ready_q
// Ready queue: circular buffer in memory, head word read every cycle.
// ----------------------------------------------------------------------------
module rrts_ready_q (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rrts_pkg::t_q_req           i_req,
    output logic [rrts_pkg::SLOT_W-1:0] o_head,
    output logic                       o_empty,
    output logic                       o_full
);
    import rrts_pkg::*;

    logic [SLOT_W-1:0] r_mem [SLOTS];
    logic [SLOT_W-1:0] r_head, r_tail, r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(SLOTS));
    assign do_push = i_req.push && !o_full;
    assign do_pop  = i_req.pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_req.data;
        end
        r_q <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (do_pop) begin
                r_head <= r_head + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    assign o_head = r_q;
endmodule

>>> rtl/rrts_free_find.sv
// ----------------------------------------------------------------------------
// rrts_free_find
// Free-slot bitmap and two-stage lowest-free search (group, then bit).
// ----------------------------------------------------------------------------
module rrts_free_find (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rrts_pkg::t_free_req        i_req,
    output logic                       o_found,
    output logic [rrts_pkg::SLOT_W-1:0] o_slot
);
    import rrts_pkg::*;

    logic [SLOTS-1:0] r_free;
    logic [NGRP-1:0]  grp_any;
    logic [GRP_W-1:0] grp_sel, r_grp;
    logic [GRP-1:0]   grp_bits;
    logic [BIT_W-1:0] bit_sel;
    logic             r_any, r_found;
    logic [SLOT_W-1:0] r_slot;

    always_comb begin
        grp_sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            grp_any[g] = |r_free[g*GRP +: GRP];
            if (grp_any[g]) begin
                grp_sel = GRP_W'(g);
            end
        end
    end

    always_comb begin
        grp_bits = r_free[r_grp*GRP +: GRP];
        bit_sel  = '0;
        for (int b = GRP - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                bit_sel = BIT_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= grp_sel;
        r_any  <= |grp_any;
        r_slot <= {r_grp, bit_sel};
        r_found <= r_any;
    end

    // slot 0 is the idle thread and is never free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= {{(SLOTS-1){1'b1}}, 1'b0};
        end else if (i_req.set_free) begin
            r_free[i_req.addr] <= 1'b1;
        end else if (i_req.clr_free) begin
            r_free[i_req.addr] <= 1'b0;
        end
    end

    assign o_found = r_found;
    assign o_slot  = r_slot;
endmodule

>>> rtl/round_robin_thread_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Slot-table thread scheduler with FIFO ready queue and round-robin pick.
// ----------------------------------------------------------------------------
// One request carries an action (yield, create, sleep, wakeup, join, exit);
// the block applies it to the slot table, then reschedules and returns one
// result with the status, the running slot and id, any created slot and any
// exit value handed to a joiner. Requests are handled one at a time by a
// sequencer around a slot-table memory with one read and one write port
// and a registered read, so the cost is set by the number of table
// accesses each action makes; the sequencer takes the next request only
// once it is back in its idle state. The ready queue and the free-slot
// search run beside it. A result waits in an output register, and the
// next request is taken while it waits. No clearing pass after reset: the
// table keeps one valid flag per slot.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // target_slot[7:0], exit_value[39:8]
    input  logic [2:0]   s_axis_tuser,  // action[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], current_slot[9:2], current_id[41:10], new_slot[49:42],
    // new_id[81:50], handed_valid[82], handed_slot[90:83],
    // handed_value[122:91], zero[127:123]
    output logic [127:0] m_axis_tdata
);
    import rrts_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR0  = 4'd1;
    localparam logic [3:0] S_CR1  = 4'd2;
    localparam logic [3:0] S_CR2  = 4'd3;
    localparam logic [3:0] S_W1   = 4'd4;
    localparam logic [3:0] S_A1   = 4'd5;
    localparam logic [3:0] S_J2   = 4'd6;
    localparam logic [3:0] S_J3   = 4'd7;
    localparam logic [3:0] S_X2   = 4'd8;
    localparam logic [3:0] S_X3   = 4'd9;
    localparam logic [3:0] S_RS0  = 4'd10;
    localparam logic [3:0] S_RS1  = 4'd11;
    localparam logic [3:0] S_RS2  = 4'd12;
    localparam logic [3:0] S_RS3  = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0]        r_state, n_state;
    logic [2:0]        r_act, n_act;
    logic [SLOT_W-1:0] r_tgt, n_tgt;
    logic [31:0]       r_val, n_val;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [31:0]       r_nid, n_nid;
    logic [1:0]        r_err, n_err;
    logic              r_ovf, n_ovf;
    logic [SLOT_W-1:0] r_new_slot, n_new_slot;
    logic [31:0]       r_new_id, n_new_id;
    logic              r_hv, n_hv;
    logic [SLOT_W-1:0] r_hs, n_hs;
    logic [31:0]       r_hval, n_hval;
    t_ent              r_cent, n_cent;
    logic [1:0]        r_pst, n_pst;
    logic [SLOT_W-1:0] r_nxt, n_nxt;
    logic [31:0]       r_cid, n_cid;
    logic              r_ov, n_ov;
    logic [127:0]      r_odata, n_odata;

    t_tbl_req          tbl_req;
    t_ent              rd_ent;
    t_q_req            q_req;
    logic [SLOT_W-1:0] q_head;
    logic              q_empty, q_full;
    t_free_req         free_req;
    logic              ff_found;
    logic [SLOT_W-1:0] ff_slot;
    logic              s_acc;
    logic [SLOT_W-1:0] nxt;
    t_ent              went;

    rrts_slot_tbl u_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (tbl_req),
        .o_rd_ent (rd_ent)
    );

    rrts_ready_q u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rrts_free_find u_ff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (free_req),
        .o_found (ff_found),
        .o_slot  (ff_slot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_state    = r_state;
        n_act      = r_act;
        n_tgt      = r_tgt;
        n_val      = r_val;
        n_cur      = r_cur;
        n_nid      = r_nid;
        n_err      = r_err;
        n_ovf      = r_ovf;
        n_new_slot = r_new_slot;
        n_new_id   = r_new_id;
        n_hv       = r_hv;
        n_hs       = r_hs;
        n_hval     = r_hval;
        n_cent     = r_cent;
        n_pst      = r_pst;
        n_nxt      = r_nxt;
        n_cid      = r_cid;
        n_odata    = r_odata;
        n_ov       = r_ov && !m_axis_tready;
        tbl_req    = '0;
        q_req      = '0;
        free_req   = '0;
        nxt        = '0;
        went       = rd_ent;

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_act      = s_axis_tuser;
                    n_tgt      = s_axis_tdata[7:0];
                    n_val      = s_axis_tdata[39:8];
                    n_err      = STS_OK;
                    n_ovf      = 1'b0;
                    n_new_slot = '0;
                    n_new_id   = '0;
                    n_hv       = 1'b0;
                    n_hs       = '0;
                    n_hval     = '0;
                    case (s_axis_tuser)
                        ACT_CREATE: n_state = S_CR0;
                        ACT_WAKEUP: begin
                            tbl_req.rd_en   = 1'b1;
                            tbl_req.rd_addr = s_axis_tdata[7:0];
                            n_state         = S_W1;
                        end
                        ACT_SLEEP, ACT_JOIN, ACT_EXIT: begin
                            tbl_req.rd_en   = 1'b1;
                            tbl_req.rd_addr = r_cur;
                            n_state         = S_A1;
                        end
                        default: n_state = S_RS0;
                    endcase
                end
            end
            // let the free-slot search settle
            S_CR0: n_state = S_CR1;
            S_CR1: n_state = S_CR2;
            S_CR2: begin
                if (!ff_found) begin
                    n_err = STS_NOSLOT;
                end else begin
                    went            = '0;
                    went.state      = SS_RUN;
                    went.ident      = r_nid;
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = ff_slot;
                    tbl_req.wr_ent  = went;
                    free_req.clr_free = 1'b1;
                    free_req.addr   = ff_slot;
                    n_new_slot      = ff_slot;
                    n_new_id        = r_nid;
                    n_nid           = r_nid + 32'd1;
                    q_req.push      = 1'b1;
                    q_req.data      = ff_slot;
                    if (q_full) begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_RS0;
            end
            S_W1: begin
                if (r_tgt != '0 && rd_ent.state == SS_SLEEP) begin
                    went.state      = SS_RUN;
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_tgt;
                    tbl_req.wr_ent  = went;
                    q_req.push      = 1'b1;
                    q_req.data      = r_tgt;
                    if (q_full) begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_RS0;
            end
            S_A1: begin
                n_cent  = rd_ent;
                n_state = S_RS0;
                case (r_act)
                    ACT_SLEEP: begin
                        if (r_cur != '0) begin
                            went.state      = SS_SLEEP;
                            tbl_req.wr_en   = 1'b1;
                            tbl_req.wr_addr = r_cur;
                            tbl_req.wr_ent  = went;
                        end
                    end
                    ACT_JOIN: begin
                        if (r_cur == '0 || r_tgt == r_cur) begin
                            n_err = STS_BADJOIN;
                        end else begin
                            tbl_req.rd_en   = 1'b1;
                            tbl_req.rd_addr = r_tgt;
                            n_state         = S_J2;
                        end
                    end
                    default: begin
                        // exit: hand the value first, then mark dead
                        if (r_cur != '0) begin
                            if (rd_ent.jv) begin
                                n_hv            = 1'b1;
                                n_hs            = rd_ent.js;
                                n_hval          = r_val;
                                tbl_req.rd_en   = 1'b1;
                                tbl_req.rd_addr = rd_ent.js;
                                n_state         = S_X2;
                            end else begin
                                n_state = S_X3;
                            end
                        end
                    end
                endcase
            end
            S_J2: begin
                if (rd_ent.state == SS_UNUSED || rd_ent.jv) begin
                    n_err   = STS_BADJOIN;
                    n_state = S_RS0;
                end else begin
                    went.jv         = 1'b1;
                    went.js         = r_cur;
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_tgt;
                    tbl_req.wr_ent  = went;
                    n_state         = S_J3;
                end
            end
            S_J3: begin
                went            = r_cent;
                went.state      = SS_SLEEP;
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = r_cur;
                tbl_req.wr_ent  = went;
                n_state         = S_RS0;
            end
            S_X2: begin
                if (r_hs != '0 && rd_ent.state == SS_SLEEP) begin
                    went.state      = SS_RUN;
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = r_hs;
                    tbl_req.wr_ent  = went;
                    q_req.push      = 1'b1;
                    q_req.data      = r_hs;
                    if (q_full) begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_X3;
            end
            S_X3: begin
                went            = r_cent;
                went.state      = SS_DEAD;
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = r_cur;
                tbl_req.wr_ent  = went;
                n_state         = S_RS0;
            end
            S_RS0: begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = r_cur;
                n_state         = S_RS1;
            end
            // pick the next thread; free a dead previous slot
            S_RS1: begin
                if (!q_empty) begin
                    nxt       = q_head;
                    q_req.pop = 1'b1;
                end else if (r_cur != '0 && rd_ent.state == SS_RUN) begin
                    nxt = r_cur;
                end
                if (rd_ent.state == SS_DEAD) begin
                    tbl_req.wr_en     = 1'b1;
                    tbl_req.wr_addr   = r_cur;
                    tbl_req.wr_ent    = '0;
                    free_req.set_free = 1'b1;
                    free_req.addr     = r_cur;
                    if (nxt == r_cur) begin
                        nxt = '0;
                    end
                end
                n_pst   = rd_ent.state;
                n_nxt   = nxt;
                n_state = S_RS2;
            end
            S_RS2: begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = r_nxt;
                n_state         = S_RS3;
            end
            S_RS3: begin
                nxt   = (rd_ent.state == SS_UNUSED) ? '0 : r_nxt;
                n_cid = (rd_ent.state == SS_UNUSED) ? 32'd0 : rd_ent.ident;
                if (r_cur != '0 && r_cur != nxt && r_pst == SS_RUN) begin
                    q_req.push = 1'b1;
                    q_req.data = r_cur;
                    if (q_full) begin
                        n_ovf = 1'b1;
                    end
                end
                if (r_err == STS_OK && n_ovf) begin
                    n_err = STS_OVF;
                end
                n_cur   = nxt;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || m_axis_tready) begin
                    n_odata = {5'd0, r_hval, r_hs, r_hv, r_new_id, r_new_slot,
                               r_cid, r_cur, r_err};
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_nid   <= 32'd1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_nid   <= n_nid;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_tgt      <= n_tgt;
        r_val      <= n_val;
        r_err      <= n_err;
        r_ovf      <= n_ovf;
        r_new_slot <= n_new_slot;
        r_new_id   <= n_new_id;
        r_hv       <= n_hv;
        r_hs       <= n_hs;
        r_hval     <= n_hval;
        r_cent     <= n_cent;
        r_pst      <= n_pst;
        r_nxt      <= n_nxt;
        r_cid      <= n_cid;
        r_odata    <= n_odata;
    end
endmodule

>>> rtl/rrts_chk.sv
// ----------------------------------------------------------------------------
// rrts_chk
// Port-level checks on the thread scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_thread_scheduler_assert.svh"

module rrts_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [39:0]  s_axis_tdata,
    input logic [2:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    // hold a stalled result
    `RRTS_AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // the idle thread has id zero
    `RRTS_AST_NOW(a_idle_id, m_axis_tvalid && m_axis_tdata[9:2] == 8'd0, m_axis_tdata[41:10] == 32'd0)
    // no handed slot or value without the handed_valid flag
    `RRTS_AST_NOW(a_hand_zero, m_axis_tvalid && !m_axis_tdata[82], m_axis_tdata[122:83] == 40'd0)
    // a failed create gives no slot
    `RRTS_AST_NOW(a_noslot, m_axis_tvalid && m_axis_tdata[1:0] == 2'd1, m_axis_tdata[81:42] == 40'd0)
endmodule

bind round_robin_thread_scheduler rrts_chk u_rrts_chk (.*);
